// ===== hdl/ssewr_pkg.sv =====
// Package for the sum-squared-error stage with target and zero-error radii.
// Holds the widths, register indexes and derived constants shared by all files.
// No dependencies.
`default_nettype none

package ssewr_pkg;

  // Data and accumulator widths
  localparam int DATA_WIDTH  = 16;
  localparam int ACC_WIDTH   = 48;
  localparam int DERIV_WIDTH = DATA_WIDTH + 1;
  localparam int SQ_WIDTH    = 2 * DERIV_WIDTH;
  localparam int SUM_WIDTH   = ACC_WIDTH - 1;

  // Stream word widths, padded to whole bytes
  localparam int IN_TDATA_WIDTH  = ((2 * DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS  = DERIV_WIDTH + SUM_WIDTH + 1;
  localparam int OUT_TDATA_WIDTH = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // Configuration register indexes
  localparam int CFG_ADDR_WIDTH = 1;
  typedef enum logic [CFG_ADDR_WIDTH-1:0] {
    REG_STEP_RADIUS = 1'b0,
    REG_ZERO_RADIUS = 1'b1
  } cfg_reg_t;

  // Radii handed to the target adjustment logic
  typedef struct packed {
    logic [DATA_WIDTH-1:0] step_radius;
    logic [DATA_WIDTH-1:0] zero_radius;
  } radius_cfg_t;

  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

endpackage : ssewr_pkg

`default_nettype wire

// ===== hdl/ssewr_adjust.sv =====
// Target adjustment: applies the zero-error and target radii and returns the
// derivative, activation minus adjusted target. Uses ssewr_pkg.
`default_nettype none

module ssewr_adjust
  import ssewr_pkg::*;
(
  input  wire logic signed [DATA_WIDTH-1:0]  activation,
  input  wire logic signed [DATA_WIDTH-1:0]  target,
  input  wire radius_cfg_t                   radii,
  output logic signed [DERIV_WIDTH-1:0]      derivative
);

  // One guard bit above the difference so the radius sums cannot wrap.
  localparam int W = DERIV_WIDTH + 1;

  logic signed [W-1:0] diff;
  logic signed [W-1:0] zr;
  logic signed [W-1:0] tr;
  logic signed [W-1:0] result;

  assign diff = W'(activation) - W'(target);
  assign zr   = W'({2'b00, radii.zero_radius});
  assign tr   = W'({2'b00, radii.step_radius});

  // Inside the zero band the error is nil; beyond the target radius the
  // target steps toward the activation; otherwise the target is met.
  always_comb begin
    if ((diff < zr) && (diff > -zr)) begin
      result = '0;
    end else if (diff > tr) begin
      result = diff - tr;
    end else if (diff < -tr) begin
      result = diff + tr;
    end else begin
      result = '0;
    end
  end

  // A step never passes the activation, so the result fits the narrower width.
  assign derivative = result[DERIV_WIDTH-1:0];

endmodule : ssewr_adjust

`default_nettype wire

// ===== hdl/sum_squared_error_with_radius.sv =====
// Sum-squared-error stage with target and zero-error radii: top level.
// Uses ssewr_pkg and ssewr_adjust.
//
// Usage:
//  - in_*: one word per element, activation and target (signed Q4.12);
//    in_tlast marks the final element of a vector.
//  - out_*: one word per input word, carrying the derivative, the half sum of
//    squares (24 fraction bits, non-zero only on the final word of a vector)
//    and the clip flag; out_tlast copies in_tlast.
//  - cfg_*: write-only registers, target radius (index 0) and zero radius (index 1),
//    to be written by the user only while no word is in flight; the block does not enforce it.
// Throughput is one word per cycle while out_tready stays high, set by a
// four-register pipeline: input register, derivative register, square
// register and output register, with the saturating accumulator updated
// as a word enters the output register.
// Synchronous reset empties the pipeline, clears the accumulator and the
// clip flag and sets both radii to zero.
// When the receiver stalls, the output holds its word; earlier stages keep
// filling until every stage is occupied, and only then is in_tready lowered.
`default_nettype none

module sum_squared_error_with_radius
  import ssewr_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Input stream
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [IN_TDATA_WIDTH-1:0]   in_tdata,   // activation, target
  input  wire logic                        in_tlast,
  // Result stream
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [OUT_TDATA_WIDTH-1:0]       out_tdata,  // derivative, error_sum, saturated, pad
  output logic                             out_tlast,
  // Configuration
  input  wire logic                        cfg_we,
  input  wire logic [CFG_ADDR_WIDTH-1:0]   cfg_addr,
  input  wire logic [DATA_WIDTH-1:0]       cfg_wdata
);

  // Configuration registers
  radius_cfg_t radii_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radii_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_STEP_RADIUS: radii_r.step_radius <= cfg_wdata;
        REG_ZERO_RADIUS: radii_r.zero_radius <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage valid flags and advance conditions
  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;

  assign adv4      = !v4_r || out_tready;
  assign adv3      = !v3_r || adv4;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign in_tready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_tvalid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  // Stage 1: input register
  logic signed [DATA_WIDTH-1:0] act_r, tgt_r;
  logic                         last1_r;

  always_ff @(posedge clk) begin
    if (adv1) begin
      act_r   <= in_tdata[DATA_WIDTH-1:0];
      tgt_r   <= in_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
      last1_r <= in_tlast;
    end
  end

  // Stage 2: derivative after target adjustment
  logic signed [DERIV_WIDTH-1:0] deriv_nxt;
  logic signed [DERIV_WIDTH-1:0] deriv2_r;
  logic                          last2_r;

  ssewr_adjust u_adjust (
    .activation (act_r),
    .target     (tgt_r),
    .radii      (radii_r),
    .derivative (deriv_nxt)
  );

  always_ff @(posedge clk) begin
    if (adv2) begin
      deriv2_r <= deriv_nxt;
      last2_r  <= last1_r;
    end
  end

  // Stage 3: square of the derivative magnitude
  logic [DERIV_WIDTH-1:0]        mag;
  logic [SQ_WIDTH-1:0]           sq_r;
  logic signed [DERIV_WIDTH-1:0] deriv3_r;
  logic                          last3_r;

  assign mag = deriv2_r[DERIV_WIDTH-1] ? DERIV_WIDTH'(-deriv2_r) : DERIV_WIDTH'(deriv2_r);

  always_ff @(posedge clk) begin
    if (adv3) begin
      sq_r     <= mag * mag;
      deriv3_r <= deriv2_r;
      last3_r  <= last2_r;
    end
  end

  // Stage 4: saturating accumulation into the output register
  logic [ACC_WIDTH-1:0] acc_r, acc_nxt;
  logic                 clip_r, clip_nxt;
  logic [ACC_WIDTH:0]   acc_sum;
  logic                 load4;

  assign load4   = adv4 && v3_r;
  assign acc_sum = {1'b0, acc_r} + (ACC_WIDTH + 1)'(sq_r);

  always_comb begin
    if (acc_sum[ACC_WIDTH]) begin
      acc_nxt  = ACC_MAX;
      clip_nxt = 1'b1;
    end else begin
      acc_nxt  = acc_sum[ACC_WIDTH-1:0];
      clip_nxt = clip_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      clip_r <= 1'b0;
    end else if (load4) begin
      acc_r  <= last3_r ? '0 : acc_nxt;
      clip_r <= last3_r ? 1'b0 : clip_nxt;
    end
  end

  // Output word register
  logic signed [DERIV_WIDTH-1:0] deriv4_r;
  logic [SUM_WIDTH-1:0]          sum4_r;
  logic                          sat4_r;
  logic                          last4_r;

  always_ff @(posedge clk) begin
    if (load4) begin
      deriv4_r <= deriv3_r;
      sum4_r   <= last3_r ? acc_nxt[ACC_WIDTH-1:1] : '0;
      sat4_r   <= clip_nxt;
      last4_r  <= last3_r;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tlast  = last4_r;
  assign out_tdata  = {{(OUT_TDATA_WIDTH - OUT_FIELD_BITS){1'b0}}, sat4_r, sum4_r, deriv4_r};

endmodule : sum_squared_error_with_radius

`default_nettype wire

// ===== test/tb_sum_squared_error_with_radius.sv =====
// Self-checking testbench for the sum-squared-error stage with target and zero-error radii.
// Predicts every result word from its own model of the radius logic and the saturating sum.
// Depends on ssewr_pkg and sum_squared_error_with_radius.
`default_nettype none

module tb_sum_squared_error_with_radius;
  import ssewr_pkg::*;

  localparam int PIPE_DEPTH     = 4;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 20;
  localparam longint unsigned SUM_CEILING = ACC_MAX;

  // One expected result word, fields as they appear on the result stream
  typedef struct packed {
    logic [DERIV_WIDTH-1:0] derivative;
    logic [SUM_WIDTH-1:0]   error_sum;
    logic                   saturated;
    logic                   last_out;
  } error_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_WIDTH-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_WIDTH-1:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  cfg_reg_t cfg_addr = REG_STEP_RADIUS;
  logic [DATA_WIDTH-1:0] cfg_wdata = '0;

  // Predictor state: the two radii, the running sum of squares and the clip flag
  logic [DATA_WIDTH-1:0] target_rad = '0;
  logic [DATA_WIDTH-1:0] zero_rad = '0;
  longint unsigned square_sum = 0;
  logic clip_seen = 1'b0;

  error_word_t error_words_due[$];
  error_word_t want;

  int idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int words_sent = 0;
  int vectors_sent = 0;
  int settings_used = 0;
  int clipped_words = 0;
  int quiet_cycles = 0;

  sum_squared_error_with_radius u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure, changed at the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Adjusts the target, accumulates the square and forms the result word.
  function automatic error_word_t predict_error_word(logic [DATA_WIDTH-1:0] act,
                                                     logic [DATA_WIDTH-1:0] tgt,
                                                     logic last);
    error_word_t w;
    longint diff;
    longint zr;
    longint tr;
    longint deriv;
    longint unsigned mag;
    longint unsigned sq;
    diff  = longint'($signed(act)) - longint'($signed(tgt));
    zr    = longint'(zero_rad);
    tr    = longint'(target_rad);
    // Strictly inside the zero band, or within the target radius: no error.
    if (diff < zr && diff > -zr) deriv = 0;
    else if (diff > tr) deriv = diff - tr;
    else if (diff < -tr) deriv = diff + tr;
    else deriv = 0;
    mag = (deriv < 0) ? longint'(-deriv) : longint'(deriv);
    sq  = mag * mag;
    // The sum sticks at its ceiling once it would overflow.
    if (sq > SUM_CEILING - square_sum) begin
      square_sum = SUM_CEILING;
      clip_seen  = 1'b1;
    end else begin
      square_sum = square_sum + sq;
    end
    w.derivative = deriv[DERIV_WIDTH-1:0];
    w.error_sum  = last ? SUM_WIDTH'(square_sum >> 1) : '0;
    w.saturated  = clip_seen;
    w.last_out   = last;
    if (last) begin
      square_sum = 0;
      clip_seen  = 1'b0;
    end
    return w;
  endfunction

  task automatic report_mismatch(string field, longint unsigned exp_val,
                                 longint unsigned got_val);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("Mismatch at %0t: %s expected 0x%0h, got 0x%0h", $realtime, field, exp_val,
               got_val);
  endtask

  // Sends one word, idling first at the sender's rate; returns at the falling edge.
  task automatic send_word(logic [DATA_WIDTH-1:0] act, logic [DATA_WIDTH-1:0] tgt,
                           logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_WIDTH'({tgt, act});
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    error_words_due.push_back(predict_error_word(act, tgt, last));
    words_sent++;
    if (last) vectors_sent++;
    @(negedge clk);
  endtask

  // Stops sending and waits until every expected word has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (error_words_due.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t which, logic [DATA_WIDTH-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= which;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (which == REG_STEP_RADIUS) target_rad = value;
    else zero_rad = value;
  endtask

  task automatic set_radii(logic [DATA_WIDTH-1:0] tr, logic [DATA_WIDTH-1:0] zr);
    wait_drained();
    write_reg(REG_STEP_RADIUS, tr);
    write_reg(REG_ZERO_RADIUS, zr);
    settings_used++;
  endtask

  // Activation near one of the band edges around the target, or anywhere.
  function automatic logic [DATA_WIDTH-1:0] pick_activation(logic [DATA_WIDTH-1:0] tgt);
    longint base;
    longint act;
    if ($urandom_range(3) == 0) return DATA_WIDTH'($urandom_range(65535));
    case ($urandom_range(3))
      0: base = longint'(zero_rad);
      1: base = longint'(target_rad);
      2: base = 0;
      default: base = longint'($urandom_range(65535));
    endcase
    if ($urandom_range(1) == 1) base = -base;
    act = longint'($signed(tgt)) + base + longint'($urandom_range(6)) - 3;
    if (act < -32768 || act > 32767) act = longint'($urandom_range(65535)) - 32768;
    return act[DATA_WIDTH-1:0];
  endfunction

  // Compares each result word against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (error_words_due.size() == 0) begin
        report_mismatch("unexpected result word", 0, out_tdata[DERIV_WIDTH-1:0]);
      end else begin
        want = error_words_due.pop_front();
        if (out_tdata[DERIV_WIDTH-1:0] !== want.derivative)
          report_mismatch("derivative", want.derivative, out_tdata[DERIV_WIDTH-1:0]);
        if (out_tdata[DERIV_WIDTH +: SUM_WIDTH] !== want.error_sum)
          report_mismatch("error_sum", want.error_sum, out_tdata[DERIV_WIDTH +: SUM_WIDTH]);
        if (out_tdata[DERIV_WIDTH+SUM_WIDTH] !== want.saturated)
          report_mismatch("saturated", want.saturated, out_tdata[DERIV_WIDTH+SUM_WIDTH]);
        if (out_tlast !== want.last_out)
          report_mismatch("last", want.last_out, out_tlast);
        if (want.saturated) clipped_words++;
      end
    end
  end

  // Watchdog: ends the run when neither stream moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired at %0t", $realtime);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Extremes of the difference with both radii at their reset value of zero.
  task automatic test_reset_radii();
    send_word(16'sh7FFF, 16'sh8000, 1'b0);
    send_word(16'sh8000, 16'sh7FFF, 1'b0);
    send_word(16'sh1234, 16'sh1234, 1'b0);
    send_word(16'shFFFF, 16'sh0000, 1'b1);
    send_word(16'sh0001, 16'shFFFF, 1'b1);
  endtask

  // Edges of the zero band and the target radius, huge radii and halving.
  task automatic test_radius_bands();
    set_radii(16'h1000, 16'h0800);
    send_word(16'h07FF, 16'h0000, 1'b0);
    send_word(-16'sh07FF, 16'h0000, 1'b0);
    send_word(16'h0800, 16'h0000, 1'b0);
    send_word(16'h1000, 16'h0000, 1'b0);
    send_word(16'h1001, 16'h0000, 1'b0);
    send_word(-16'sh1001, 16'h0000, 1'b0);
    send_word(16'sh7FFF, 16'sh8000, 1'b1);
    // Zero band wider than the target radius
    set_radii(16'h0100, 16'h2000);
    send_word(16'h1FFF, 16'h0000, 1'b0);
    send_word(16'h2000, 16'h0000, 1'b0);
    send_word(16'h0000, 16'h2000, 1'b1);
    set_radii(16'hFFFF, 16'h0000);
    send_word(16'sh7FFF, 16'sh8000, 1'b0);
    send_word(16'sh8000, 16'sh7FFF, 1'b1);
    set_radii(16'h0000, 16'hFFFF);
    send_word(16'sh7FFE, 16'sh8000, 1'b0);
    send_word(16'sh7FFF, 16'sh8000, 1'b0);
    send_word(16'sh8000, 16'sh7FFF, 1'b1);
    // Odd sums lose their low bit when halved
    set_radii(16'h0000, 16'h0000);
    send_word(16'h0003, 16'h0000, 1'b1);
    send_word(16'h0000, 16'h0001, 1'b1);
  endtask

  // One long vector of the largest squares builds a wide running sum.
  task automatic test_large_sums();
    idle_pct  = 0;
    stall_pct = 0;
    set_radii(16'h0000, 16'h0000);
    for (int i = 0; i < 80; i++) send_word(16'sh7FFF, 16'sh8000, i == 79);
    // The next vector must start again from an empty sum.
    send_word(16'h0002, 16'h0000, 1'b1);
  endtask

  // Random words under each idling pattern and several radius settings.
  task automatic test_random_stream();
    logic [DATA_WIDTH-1:0] tgt;
    logic [DATA_WIDTH-1:0] tr;
    logic [DATA_WIDTH-1:0] zr;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      for (int setting = 0; setting < 3; setting++) begin
        case (setting)
          0: begin
            tr = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            zr = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          end
          1: begin
            tr = DATA_WIDTH'($urandom_range(16'h1800));
            zr = DATA_WIDTH'($urandom_range(16'h1800));
          end
          default: begin
            tr = DATA_WIDTH'($urandom_range(65535));
            zr = DATA_WIDTH'($urandom_range(65535));
          end
        endcase
        set_radii(tr, zr);
        for (int i = 0; i < 150; i++) begin
          // Hold off once until the pipeline has emptied.
          if (phase == 1 && setting == 1 && i == 80) wait_drained();
          tgt = DATA_WIDTH'($urandom_range(65535));
          send_word(pick_activation(tgt), tgt, $urandom_range(5) == 0);
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_radii();
    test_radius_bands();
    test_large_sums();
    test_random_stream();
    wait_drained();
    $display("Sent %0d words in %0d vectors over %0d radius settings.", words_sent,
             vectors_sent, settings_used);
    $display("%0d result words carried the clip flag; %0d mismatches.", clipped_words,
             fail_count);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
